/* design/fisr_pkg.sv */
// Package for the fast inverse square root pipeline.
// Holds float constants, unit latencies and the leading-zero count helper.
// No dependencies.
package fisr_pkg;

	localparam logic [31:0] MAGIC_GUESS  = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN    = 32'h7fc00000;
	localparam logic [31:0] ONE_HALF     = 32'h3f000000;
	localparam logic [31:0] THREE_HALVES = 32'h3fc00000;

	localparam int MUL_LAT   = 3;
	localparam int ADD_LAT   = 4;
	localparam int STEP_LAT  = 3 * MUL_LAT + ADD_LAT;
	localparam int TOTAL_LAT = MUL_LAT + 2 * STEP_LAT + 1;

	localparam logic [0:0] REG_NEWTON_STEPS = 1'b0;
	localparam logic [1:0] STEPS_ONE        = 2'd1;
	localparam logic [1:0] STEPS_NONE       = 2'd0;

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) begin
				n = 5'(26 - i);
			end
		end
		return n;
	endfunction

endpackage

/* design/fast_inverse_square_root.sv */
// Fast inverse square root: takes a single-precision bit pattern and returns an
// approximate reciprocal square root after one or two Newton steps (newton_steps
// register at address 0, reset 2; 0 acts as 1, 3 as 2). Fully pipelined: one
// transfer per cycle unless a valid output is stalled; the chain is the halving
// multiply and two Newton steps (three multipliers, one adder each). NaNs come
// out as 0x7fc00000. Depends on fisr_pkg, fisr_fmul, fisr_newton, fisr_delay.
module fast_inverse_square_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] x_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] y_bits
);
	import fisr_pkg::*;

	logic [1:0]  steps_q;
	logic        en;
	logic [TOTAL_LAT-1:0] vld_q;
	logic [31:0] guess, guess_d, hx, hx_d, y1, y1_d, y2, ysel, y_s30;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 2'd2;
		end else if (psel && penable && pwrite && (paddr[2] == REG_NEWTON_STEPS)) begin
			steps_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_NEWTON_STEPS) ? {30'd0, steps_q} : 32'd0;

	assign en       = !(vld_q[TOTAL_LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], in_valid};
		end
	end

	assign guess = MAGIC_GUESS - {x_bits[31], x_bits[31:1]};

	fisr_fmul u_half (.clk(clk), .en(en), .a(x_bits), .b(ONE_HALF), .p(hx));

	fisr_delay #(.W(32), .N(MUL_LAT)) u_dly_guess (
		.clk(clk), .en(en), .d(guess), .q(guess_d)
	);

	fisr_newton u_step1 (.clk(clk), .en(en), .y(guess_d), .hx(hx), .r(y1));

	fisr_delay #(.W(32), .N(STEP_LAT)) u_dly_hx (.clk(clk), .en(en), .d(hx), .q(hx_d));

	fisr_newton u_step2 (.clk(clk), .en(en), .y(y1), .hx(hx_d), .r(y2));

	fisr_delay #(.W(32), .N(STEP_LAT)) u_dly_y1 (.clk(clk), .en(en), .d(y1), .q(y1_d));

	always_comb begin
		ysel = (steps_q inside {STEPS_ONE, STEPS_NONE}) ? y1_d : y2;
		if ((ysel[30:23] == 8'hff) && (ysel[22:0] != 23'd0)) begin
			ysel = CANON_NAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s30 <= ysel;
		end
	end

	assign out_valid = vld_q[TOTAL_LAT-1];
	assign y_bits    = y_s30;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted transfer not tracked");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(y_bits)))
		else $error("stalled result lost");

	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (y_bits[30:23] == 8'hff) && (y_bits[22:0] != 23'd0))
		|-> (y_bits == CANON_NAN))
		else $error("non-canonical NaN");
endmodule

/* design/fisr_delay.sv */
// Enabled delay line that keeps operands aligned with the float units.
// Depends on nothing.
module fisr_delay #(
	parameter int W = 32,
	parameter int N = 3
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];
endmodule

/* design/fisr_fmul.sv */
// Three-stage single-precision multiplier, round to nearest even, gradual underflow.
// Depends on fisr_pkg.
module fisr_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	import fisr_pkg::*;

	logic [7:0]  ea, eb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma_raw, mb_raw;
	logic [4:0]  lza, lzb;
	logic signed [9:0] exa, exb;

	logic [23:0] ma_s1, mb_s1;
	logic signed [9:0] ex_s1;
	logic        sign_s1, nan_s1, inf_s1, zero_s1;

	logic [47:0] prod_s2;
	logic signed [9:0] ex_s2;
	logic        sign_s2, nan_s2, inf_s2, zero_s2;

	logic [47:0] pn, shifted, mask;
	logic signed [9:0] e, shf;
	logic [5:0]  sh;
	logic [23:0] m;
	logic        g, s, lost, up;
	logic [7:0]  fld;
	logic [30:0] mag;
	logic [31:0] res;
	logic [31:0] p_s3;

	always_comb begin
		ea     = a[30:23];
		eb     = b[30:23];
		a_nan  = (ea == 8'hff) && (a[22:0] != 23'd0);
		b_nan  = (eb == 8'hff) && (b[22:0] != 23'd0);
		a_inf  = (ea == 8'hff) && (a[22:0] == 23'd0);
		b_inf  = (eb == 8'hff) && (b[22:0] == 23'd0);
		a_zero = (ea == 8'h00) && (a[22:0] == 23'd0);
		b_zero = (eb == 8'h00) && (b[22:0] == 23'd0);
		ma_raw = {ea != 8'h00, a[22:0]};
		mb_raw = {eb != 8'h00, b[22:0]};
		lza    = lzc27({ma_raw, 3'b000});
		lzb    = lzc27({mb_raw, 3'b000});
		exa    = signed'({2'b00, (ea == 8'h00) ? 8'd1 : ea}) - signed'({5'b00000, lza});
		exb    = signed'({2'b00, (eb == 8'h00) ? 8'd1 : eb}) - signed'({5'b00000, lzb});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= ma_raw << lza;
			mb_s1   <= mb_raw << lzb;
			ex_s1   <= exa + exb - 10'sd127;
			sign_s1 <= a[31] ^ b[31];
			nan_s1  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
			inf_s1  <= a_inf | b_inf;
			zero_s1 <= a_zero | b_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ma_s1 * mb_s1;
			ex_s2   <= ex_s1;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
		end
	end

	always_comb begin
		pn  = prod_s2[47] ? prod_s2 : {prod_s2[46:0], 1'b0};
		e   = ex_s2 + signed'({9'd0, prod_s2[47]});
		shf = 10'sd1 - e;
		if (e >= 10'sd1) begin
			sh = 6'd0;
		end else if (shf > 10'sd48) begin
			sh = 6'd48;
		end else begin
			sh = shf[5:0];
		end
		shifted = pn >> sh;
		mask    = ~({48{1'b1}} << sh);
		lost    = |(pn & mask);
		m       = shifted[47:24];
		g       = shifted[23];
		s       = (|shifted[22:0]) | lost;
		up      = g & (s | m[0]);
		fld     = (e >= 10'sd1) ? e[7:0] : 8'd0;
		mag     = {fld, m[22:0]} + {30'd0, up};
		if (nan_s2) begin
			res = CANON_NAN;
		end else if (inf_s2 || (e >= 10'sd255)) begin
			res = {sign_s2, 8'hff, 23'd0};
		end else if (zero_s2) begin
			res = {sign_s2, 31'd0};
		end else begin
			res = {sign_s2, mag};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= res;
		end
	end

	assign p = p_s3;
endmodule

/* design/fisr_fadd.sv */
// Four-stage single-precision adder, round to nearest even, gradual underflow.
// Depends on fisr_pkg.
module fisr_fadd (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] r
);
	import fisr_pkg::*;

	logic        a_nan, b_nan, a_inf, b_inf, swap;
	logic [31:0] big, sml;
	logic [7:0]  eb_eff, es_eff;

	logic [23:0] mbig_s1, msml_s1;
	logic [7:0]  d_s1, e_s1;
	logic        sub_s1, sign_s1, nan_s1, inf_s1, isgn_s1, zsgn_s1;

	logic [4:0]  dc;
	logic [26:0] sm, al, msk;
	logic [27:0] sum;
	logic [27:0] r_s2;
	logic [7:0]  e_s2;
	logic        sign_s2, nan_s2, inf_s2, isgn_s2, zsgn_s2;

	logic [4:0]  lz, sh;
	logic [7:0]  lim;
	logic [26:0] rn;
	logic [8:0]  en9;
	logic [26:0] rn_s3;
	logic [8:0]  e_s3;
	logic        zero_s3, sign_s3, nan_s3, inf_s3, isgn_s3, zsgn_s3;

	logic [23:0] m;
	logic        up;
	logic [7:0]  fld;
	logic [30:0] mag;
	logic [31:0] res, r_s4;

	always_comb begin
		a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		swap   = b[30:0] > a[30:0];
		big    = swap ? b : a;
		sml    = swap ? a : b;
		eb_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es_eff = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mbig_s1 <= {big[30:23] != 8'd0, big[22:0]};
			msml_s1 <= {sml[30:23] != 8'd0, sml[22:0]};
			d_s1    <= eb_eff - es_eff;
			e_s1    <= eb_eff;
			sub_s1  <= a[31] ^ b[31];
			sign_s1 <= big[31];
			nan_s1  <= a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
			inf_s1  <= a_inf | b_inf;
			isgn_s1 <= a_inf ? a[31] : b[31];
			zsgn_s1 <= a[31] & b[31];
		end
	end

	always_comb begin
		dc  = (d_s1 > 8'd27) ? 5'd27 : d_s1[4:0];
		sm  = {msml_s1, 3'b000};
		msk = ~({27{1'b1}} << dc);
		al  = sm >> dc;
		al[0] = al[0] | (|(sm & msk));
		if (sub_s1) begin
			sum = {1'b0, mbig_s1, 3'b000} - {1'b0, al};
		end else begin
			sum = {1'b0, mbig_s1, 3'b000} + {1'b0, al};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= sum;
			e_s2    <= e_s1;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			isgn_s2 <= isgn_s1;
			zsgn_s2 <= zsgn_s1;
		end
	end

	always_comb begin
		lz  = lzc27(r_s2[26:0]);
		lim = e_s2 - 8'd1;
		sh  = ({3'd0, lz} > lim) ? lim[4:0] : lz;
		if (r_s2[27]) begin
			rn  = {r_s2[27:2], r_s2[1] | r_s2[0]};
			en9 = {1'b0, e_s2} + 9'd1;
		end else begin
			rn  = r_s2[26:0] << sh;
			en9 = {1'b0, e_s2} - {4'd0, sh};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s3   <= rn;
			e_s3    <= en9;
			zero_s3 <= r_s2 == 28'd0;
			sign_s3 <= sign_s2;
			nan_s3  <= nan_s2;
			inf_s3  <= inf_s2;
			isgn_s3 <= isgn_s2;
			zsgn_s3 <= zsgn_s2;
		end
	end

	always_comb begin
		m   = rn_s3[26:3];
		up  = rn_s3[2] & (rn_s3[1] | rn_s3[0] | m[0]);
		fld = rn_s3[26] ? e_s3[7:0] : 8'd0;
		mag = {fld, m[22:0]} + {30'd0, up};
		if (nan_s3) begin
			res = CANON_NAN;
		end else if (inf_s3) begin
			res = {isgn_s3, 8'hff, 23'd0};
		end else if (zero_s3) begin
			res = {zsgn_s3, 31'd0};
		end else if (e_s3 >= 9'd255) begin
			res = {sign_s3, 8'hff, 23'd0};
		end else begin
			res = {sign_s3, mag};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4 <= res;
		end
	end

	assign r = r_s4;
endmodule

/* design/fisr_newton.sv */
// One Newton step y * (1.5 - (hx * y) * y) built from three multipliers and one adder.
// Depends on fisr_pkg, fisr_fmul, fisr_fadd, fisr_delay.
module fisr_newton (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] y,
	input  logic [31:0] hx,
	output logic [31:0] r
);
	import fisr_pkg::*;

	logic [31:0] t1, t2, t3, y_d1, y_d2;

	fisr_fmul u_mul_hy (.clk(clk), .en(en), .a(hx), .b(y), .p(t1));

	fisr_delay #(.W(32), .N(MUL_LAT)) u_dly_y1 (.clk(clk), .en(en), .d(y), .q(y_d1));

	fisr_fmul u_mul_yy (.clk(clk), .en(en), .a(t1), .b(y_d1), .p(t2));

	fisr_delay #(.W(32), .N(MUL_LAT + ADD_LAT)) u_dly_y2 (
		.clk(clk), .en(en), .d(y_d1), .q(y_d2)
	);

	fisr_fadd u_sub (
		.clk(clk), .en(en), .a(THREE_HALVES), .b({~t2[31], t2[30:0]}), .r(t3)
	);

	fisr_fmul u_mul_out (.clk(clk), .en(en), .a(y_d2), .b(t3), .p(r));
endmodule
